// File: rtl/hdgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heat diffusion grid step package
// Shared types and constants for the grid step core and its submodules.
// ----------------------------------------------------------------------------
package hdgs_pkg;

  localparam int GRID_SIZE = 128;
  localparam int COORD_W   = $clog2(GRID_SIZE);
  localparam int CELL_W    = 2 * COORD_W;
  localparam int CELLS     = GRID_SIZE * GRID_SIZE;
  localparam int TEMP_W    = 16;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 16;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_INIT  = 2'd2;
  localparam logic [1:0] MODE_STEP  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_R_COEFF    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_EN     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_TEMP   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_TEMP  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_TEMP    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_ROWS  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_COLS  = 4'd7;

  typedef struct packed {
    logic [1:0]  mode;
    logic [6:0]  row;
    logic [6:0]  col;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] temperature;
    logic [1:0]  finished_mode;
  } out_item_t;

  typedef struct packed {
    logic [14:0] r_coeff;
    logic        boundary_periodic;
    logic        source_enable;
    logic [15:0] source_temp;
    logic [15:0] edge_temp;
    logic [15:0] background_temp;
    logic [13:0] rect_rows;
    logic [13:0] rect_cols;
  } cfg_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } cmd_head_t;

endpackage

// File: rtl/heat_diffusion_grid_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heat diffusion grid step core
// Two-dimensional explicit heat diffusion on a 128 by 128 grid in Q8.8.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_stall as in_item and land in a two-entry
// queue, so the sender is held off only while two requests wait. Each
// request yields exactly one result on out_valid/out_stall, in order.
// An initialize writes one cell per cycle. A step reads the five cells
// of each stencil through the single read port of the current bank, one
// per cycle, then multiplies and writes the new value into the other
// bank. Results sit in an output register; while the receiver stalls
// the engine holds its finished result and the queue keeps taking
// requests until full. The cfg_ port writes registers by index and
// must be used only while the core is idle. Reset clears the queue, the
// bank select and the registers to their defaults; grid contents are
// undefined until written.
// ----------------------------------------------------------------------------
module heat_diffusion_grid_step_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  hdgs_pkg::in_item_t               in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output hdgs_pkg::out_item_t              out_item,
  input  logic                             cfg_we,
  input  logic [hdgs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hdgs_pkg::CFG_DAT_W-1:0]   cfg_wdata
);
  import hdgs_pkg::*;

  cfg_t      cfg_r;
  cmd_head_t head;
  logic      pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.r_coeff           <= 15'd6554;
      cfg_r.boundary_periodic <= 1'b1;
      cfg_r.source_enable     <= 1'b0;
      cfg_r.source_temp       <= 16'd25600;
      cfg_r.edge_temp         <= 16'd12800;
      cfg_r.background_temp   <= 16'd12800;
      cfg_r.rect_rows         <= 14'd3731;
      cfg_r.rect_cols         <= 14'd7591;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_R_COEFF:   cfg_r.r_coeff           <= cfg_wdata[14:0];
        CFG_PERIODIC:  cfg_r.boundary_periodic <= cfg_wdata[0];
        CFG_SRC_EN:    cfg_r.source_enable     <= cfg_wdata[0];
        CFG_SRC_TEMP:  cfg_r.source_temp       <= cfg_wdata;
        CFG_EDGE_TEMP: cfg_r.edge_temp         <= cfg_wdata;
        CFG_BG_TEMP:   cfg_r.background_temp   <= cfg_wdata;
        CFG_RECT_ROWS: cfg_r.rect_rows         <= cfg_wdata[13:0];
        CFG_RECT_COLS: cfg_r.rect_cols         <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  hdgs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .head     (head),
    .pop      (pop)
  );

  hdgs_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// File: rtl/hdgs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heat diffusion grid step front end
// Accepts requests and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module hdgs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hdgs_pkg::in_item_t in_item,
  output hdgs_pkg::cmd_head_t head,
  input  logic              pop
);
  import hdgs_pkg::*;

  in_item_t   q_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, do_pop;

  assign in_stall   = (cnt_r == 2'd2);
  assign push       = in_valid && !in_stall;
  assign do_pop     = pop && (cnt_r != 2'd0);
  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= in_item;
    end
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (do_pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/hdgs_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heat diffusion grid step engine
// Executes queued requests on the two grid banks and registers the result.
// ----------------------------------------------------------------------------
module hdgs_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  hdgs_pkg::cfg_t      cfg,
  input  hdgs_pkg::cmd_head_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output hdgs_pkg::out_item_t out_item
);
  import hdgs_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_WR   = 8'b0000_0010,
    ST_RD   = 8'b0000_0100,
    ST_RD2  = 8'b0000_1000,
    ST_INIT = 8'b0001_0000,
    ST_SCAN = 8'b0010_0000,
    ST_MUL  = 8'b0100_0000,
    ST_WB   = 8'b1000_0000
  } state_t;

  localparam logic [COORD_W-1:0] LAST = COORD_W'(GRID_SIZE - 1);
  localparam logic [CELL_W-1:0]  LAST_CELL = CELL_W'(CELLS - 1);

  state_t              state_r, state_nxt;
  in_item_t            cmd_r;
  logic                active_r;
  logic                resp_r;
  logic [CELL_W-1:0]   cell_r;
  logic [2:0]          ph_r;
  logic [TEMP_W-1:0]   nb_r [5];
  logic [TEMP_W-1:0]   t_r;
  logic signed [34:0]  prod_r;
  logic                out_valid_r;
  out_item_t           out_item_r;
  logic [TEMP_W-1:0]   res_temp_r;

  logic [TEMP_W-1:0]   bank_a_mem [CELLS];
  logic [TEMP_W-1:0]   bank_b_mem [CELLS];
  logic [TEMP_W-1:0]   rd_a_r, rd_b_r, rd_data;

  logic [COORD_W-1:0]  row, col, up, dn, lf, rt;
  logic [CELL_W-1:0]   raddr, waddr;
  logic [TEMP_W-1:0]   wdata;
  logic                we_cur, we_nxt_bank, we_a, we_b;
  logic                border, in_rect_c, slot_free;
  logic [17:0]         nsum;
  logic signed [18:0]  lap;
  logic signed [35:0]  v, vr;
  logic [19:0]         q;
  logic [TEMP_W-1:0]   stencil_val, new_val;

  assign row = cell_r[CELL_W-1:COORD_W];
  assign col = cell_r[COORD_W-1:0];
  assign up  = (row == '0)   ? LAST : row - 1'b1;
  assign dn  = (row == LAST) ? '0   : row + 1'b1;
  assign lf  = (col == '0)   ? LAST : col - 1'b1;
  assign rt  = (col == LAST) ? '0   : col + 1'b1;

  assign border = (row == '0) || (col == '0) || (row == LAST) || (col == LAST);
  assign in_rect_c = (row >= cfg.rect_rows[6:0]) && (row <= cfg.rect_rows[13:7]) &&
                     (col >= cfg.rect_cols[6:0]) && (col <= cfg.rect_cols[13:7]);

  always_comb begin
    unique case (ph_r)
      3'd1:    raddr = {up, col};
      3'd2:    raddr = {dn, col};
      3'd3:    raddr = {row, lf};
      3'd4:    raddr = {row, rt};
      default: raddr = cell_r;
    endcase
  end

  assign rd_data = active_r ? rd_b_r : rd_a_r;

  assign nsum = 18'(nb_r[1]) + 18'(nb_r[2]) + 18'(nb_r[3]) + 18'(nb_r[4]);
  assign lap  = $signed({1'b0, nsum}) - $signed({1'b0, nb_r[0], 2'b00});

  assign v  = $signed({4'b0000, t_r, 16'h0000}) + 36'(prod_r);
  assign vr = v + 36'sd32768;
  assign q  = vr[35:16];
  always_comb begin
    if (v[35]) begin
      stencil_val = '0;
    end else if (|q[19:16]) begin
      stencil_val = 16'hFFFF;
    end else begin
      stencil_val = q[15:0];
    end
  end

  always_comb begin
    if (border && !cfg.boundary_periodic) begin
      new_val = cfg.edge_temp;
    end else if (!border && cfg.source_enable && in_rect_c) begin
      new_val = cfg.source_temp;
    end else begin
      new_val = stencil_val;
    end
  end

  always_comb begin
    we_cur      = 1'b0;
    we_nxt_bank = 1'b0;
    waddr       = cell_r;
    wdata       = new_val;
    unique case (1'b1)
      state_r[1]: begin
        we_cur = 1'b1;
        waddr  = {cmd_r.row, cmd_r.col};
        wdata  = cmd_r.value;
      end
      state_r[4]: begin
        we_cur = 1'b1;
        wdata  = in_rect_c ? cfg.source_temp : cfg.background_temp;
      end
      state_r[7]: we_nxt_bank = 1'b1;
      default: ;
    endcase
  end

  assign we_a = (we_cur && !active_r) || (we_nxt_bank && active_r);
  assign we_b = (we_cur && active_r) || (we_nxt_bank && !active_r);

  always_ff @(posedge clk) begin
    if (we_a) begin
      bank_a_mem[waddr] <= wdata;
    end
    rd_a_r <= bank_a_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      bank_b_mem[waddr] <= wdata;
    end
    rd_b_r <= bank_b_mem[raddr];
  end

  assign slot_free = !out_valid_r || !out_stall;
  assign pop = (state_r == ST_IDLE) && !resp_r && head.valid;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          unique case (head.item.mode)
            MODE_WRITE: state_nxt = ST_WR;
            MODE_READ:  state_nxt = ST_RD;
            MODE_INIT:  state_nxt = ST_INIT;
            default:    state_nxt = ST_SCAN;
          endcase
        end
      end
      ST_WR:   state_nxt = ST_IDLE;
      ST_RD:   state_nxt = ST_RD2;
      ST_RD2:  state_nxt = ST_IDLE;
      ST_INIT: state_nxt = (cell_r == LAST_CELL) ? ST_IDLE : ST_INIT;
      ST_SCAN: state_nxt = (ph_r == 3'd5) ? ST_MUL : ST_SCAN;
      ST_MUL:  state_nxt = ST_WB;
      ST_WB:   state_nxt = (cell_r == LAST_CELL) ? ST_IDLE : ST_SCAN;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= head.item;
    end
    if (state_r == ST_RD2) begin
      res_temp_r <= rd_data;
    end else if (pop) begin
      res_temp_r <= '0;
    end
    if (state_r == ST_SCAN && ph_r != 3'd0) begin
      nb_r[ph_r - 3'd1] <= rd_data;
    end
    if (state_r == ST_MUL) begin
      t_r    <= nb_r[0];
      prod_r <= $signed({1'b0, cfg.r_coeff}) * lap;
    end
    if (resp_r && slot_free) begin
      out_item_r.temperature   <= res_temp_r;
      out_item_r.finished_mode <= cmd_r.mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= 1'b0;
      resp_r      <= 1'b0;
      cell_r      <= '0;
      ph_r        <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        cell_r <= (head.item.mode == MODE_READ) ? {head.item.row, head.item.col} : '0;
        ph_r   <= 3'd0;
      end
      if (state_r == ST_SCAN) begin
        ph_r <= (ph_r == 3'd5) ? 3'd0 : ph_r + 3'd1;
      end
      if (state_r == ST_INIT || state_r == ST_WB) begin
        cell_r <= cell_r + 1'b1;
      end
      if (state_r == ST_WB && cell_r == LAST_CELL) begin
        active_r <= ~active_r;
      end
      if (state_nxt == ST_IDLE && state_r != ST_IDLE) begin
        resp_r <= 1'b1;
      end else if (resp_r && slot_free) begin
        resp_r <= 1'b0;
      end
      if (resp_r && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: tb/sv/tb_heat_diffusion_grid_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heat diffusion grid step core testbench
// Drives write, read, initialize and step requests through the valid/stall
// channel, keeps its own copy of both grid banks and the register file, and
// checks every result in order against the predicted temperature and mode.
// Runs several register settings and idling phases, including one long
// receiver hold-off that fills the request queue.
// ----------------------------------------------------------------------------
module tb_heat_diffusion_grid_step_core;
  import hdgs_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 4'd9;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  heat_diffusion_grid_step_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  bit [15:0] grid_bank [2][CELLS];
  bit [15:0] next_grid [CELLS];
  bit cur_bank;
  cfg_t regs;

  in_item_t request_q[$];
  out_item_t temp_expect_q[$];
  int in_idle_pct;
  int out_stall_pct;
  bit in_took;
  bit hold_go;
  int hold_left;
  bit hold_used;
  int errors;
  int cycles;

  function automatic bit in_rect(int r, int c);
    int r0, r1, c0, c1;
    r0 = regs.rect_rows[6:0];
    r1 = regs.rect_rows[13:7];
    c0 = regs.rect_cols[6:0];
    c1 = regs.rect_cols[6:0] == 0 ? regs.rect_cols[13:7] : regs.rect_cols[13:7];
    return r >= r0 && r <= r1 && c >= c0 && c <= c1;
  endfunction

  function automatic bit [15:0] stencil_at(int r, int c);
    int n, up, dn, lf, rt;
    longint t, sum, lap, v, q;
    n = GRID_SIZE;
    up = (r == 0) ? n - 1 : r - 1;
    dn = (r == n - 1) ? 0 : r + 1;
    lf = (c == 0) ? n - 1 : c - 1;
    rt = (c == n - 1) ? 0 : c + 1;
    t = grid_bank[cur_bank][r * n + c];
    sum = longint'(grid_bank[cur_bank][up * n + c]) + grid_bank[cur_bank][dn * n + c]
        + grid_bank[cur_bank][r * n + lf] + grid_bank[cur_bank][r * n + rt];
    lap = sum - 4 * t;
    v = t * 65536 + longint'(regs.r_coeff) * lap;
    if (v < 0) return 16'd0;
    q = (v + 32768) >>> 16;
    if (q > 65535) q = 65535;
    return q[15:0];
  endfunction

  task automatic diffuse_step();
    int n;
    bit border;
    n = GRID_SIZE;
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        border = r == 0 || c == 0 || r == n - 1 || c == n - 1;
        if (border && !regs.boundary_periodic) begin
          next_grid[r * n + c] = regs.edge_temp;
        end else if (!border && regs.source_enable && in_rect(r, c)) begin
          next_grid[r * n + c] = regs.source_temp;
        end else begin
          next_grid[r * n + c] = stencil_at(r, c);
        end
      end
    end
    for (int i = 0; i < CELLS; i++) grid_bank[!cur_bank][i] = next_grid[i];
    cur_bank = !cur_bank;
  endtask

  task automatic apply_request(in_item_t it);
    out_item_t res;
    int idx;
    idx = it.row * GRID_SIZE + it.col;
    res.temperature = 16'd0;
    res.finished_mode = it.mode;
    case (it.mode)
      MODE_WRITE: grid_bank[cur_bank][idx] = it.value;
      MODE_READ: res.temperature = grid_bank[cur_bank][idx];
      MODE_INIT: begin
        for (int r = 0; r < GRID_SIZE; r++)
          for (int c = 0; c < GRID_SIZE; c++)
            grid_bank[cur_bank][r * GRID_SIZE + c] =
              in_rect(r, c) ? regs.source_temp : regs.background_temp;
      end
      default: diffuse_step();
    endcase
    temp_expect_q.push_back(res);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Request driver.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (request_q.size() > 0 && $urandom_range(0, 99) >= in_idle_pct) begin
        in_item <= request_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, with one long hold-off on request.
  always @(negedge clk) begin
    if (hold_go && !hold_used) begin
      hold_used = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end
  end

  // Acceptance, prediction and result checking.
  always @(posedge clk) begin
    out_item_t exp_res;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("** heat_diffusion_grid_step_core: FAILED **");
      $finish;
    end
    in_took = rst_n && in_valid && !in_stall;
    if (in_took) apply_request(in_item);
    if (rst_n && out_valid && !out_stall) begin
      if (temp_expect_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: temp %h mode %0d",
                                   out_item.temperature, out_item.finished_mode);
      end else begin
        exp_res = temp_expect_q.pop_front();
        if (exp_res !== out_item) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected temp %h mode %0d, got temp %h mode %0d",
                     exp_res.temperature, exp_res.finished_mode,
                     out_item.temperature, out_item.finished_mode);
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_R_COEFF: regs.r_coeff = data[14:0];
      CFG_PERIODIC: regs.boundary_periodic = data[0];
      CFG_SRC_EN: regs.source_enable = data[0];
      CFG_SRC_TEMP: regs.source_temp = data;
      CFG_EDGE_TEMP: regs.edge_temp = data;
      CFG_BG_TEMP: regs.background_temp = data;
      CFG_RECT_ROWS: regs.rect_rows = data[13:0];
      CFG_RECT_COLS: regs.rect_cols = data[13:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_req(logic [1:0] mode, int r, int c, logic [15:0] v);
    in_item_t it;
    it.mode = mode;
    it.row = r[6:0];
    it.col = c[6:0];
    it.value = v;
    request_q.push_back(it);
  endtask

  task automatic drain();
    while (request_q.size() > 0 || in_valid || temp_expect_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_requests(int n);
    int sel;
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it = in_item_t'($urandom);
      sel = $urandom_range(0, 99);
      if (i == n / 2) it.mode = MODE_STEP;
      else if (sel < 45) it.mode = MODE_WRITE;
      else if (sel < 96) it.mode = MODE_READ;
      else it.mode = MODE_INIT;
      request_q.push_back(it);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_took = 1'b0;
    hold_go = 1'b0;
    hold_left = 0;
    hold_used = 1'b0;
    errors = 0;
    cycles = 0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    cur_bank = 1'b0;
    regs.r_coeff = 15'd6554;
    regs.boundary_periodic = 1'b1;
    regs.source_enable = 1'b0;
    regs.source_temp = 16'd25600;
    regs.edge_temp = 16'd12800;
    regs.background_temp = 16'd12800;
    regs.rect_rows = 14'd3731;
    regs.rect_cols = 14'd7591;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_req(MODE_INIT, 0, 0, 16'h0000);
    push_req(MODE_READ, 0, 0, 16'hffff);
    push_req(MODE_READ, 127, 127, 16'h0000);
    push_req(MODE_READ, 25, 45, 16'h0000);
    push_req(MODE_WRITE, 0, 0, 16'h0000);
    push_req(MODE_WRITE, 127, 127, 16'hffff);
    push_req(MODE_WRITE, 0, 127, 16'h8000);
    push_req(MODE_WRITE, 20, 40, 16'hffff);
    push_req(MODE_READ, 0, 0, 16'h0000);
    push_req(MODE_READ, 127, 127, 16'h0000);
    push_req(MODE_READ, 0, 127, 16'h0000);
    push_req(MODE_STEP, 127, 127, 16'hffff);
    push_req(MODE_READ, 0, 0, 16'h0000);
    push_req(MODE_READ, 127, 127, 16'h0000);
    push_req(MODE_READ, 0, 127, 16'h0000);
    push_req(MODE_READ, 20, 40, 16'h0000);
    push_req(MODE_READ, 19, 39, 16'h0000);
    drain();

    hold_go = 1'b1;
    for (int i = 0; i < 12; i++)
      push_req(i % 2 ? MODE_READ : MODE_WRITE, 60 + i / 2, 70, 16'(16'h1111 * i));
    drain();

    write_reg(CFG_R_COEFF, 16'd16384);
    write_reg(CFG_PERIODIC, 16'd0);
    write_reg(CFG_SRC_EN, 16'd1);
    write_reg(CFG_SRC_TEMP, 16'hffff);
    write_reg(CFG_EDGE_TEMP, 16'h0000);
    write_reg(CFG_BG_TEMP, 16'h1234);
    write_reg(CFG_RECT_ROWS, {2'b00, 7'd127, 7'd0});
    write_reg(CFG_RECT_COLS, {2'b00, 7'd90, 7'd10});
    write_reg(CFG_UNMAPPED, 16'h5a5a);
    in_idle_pct = 82;
    push_req(MODE_INIT, 0, 0, 16'h0000);
    random_requests(22);
    drain();

    write_reg(CFG_R_COEFF, 16'hffff);
    write_reg(CFG_PERIODIC, 16'd1);
    write_reg(CFG_SRC_TEMP, 16'h0000);
    write_reg(CFG_EDGE_TEMP, 16'hffff);
    write_reg(CFG_BG_TEMP, 16'hffff);
    write_reg(CFG_RECT_ROWS, {2'b11, 7'd5, 7'd100});
    write_reg(CFG_RECT_COLS, 16'hffff);
    in_idle_pct = 0;
    out_stall_pct = 82;
    push_req(MODE_INIT, 0, 0, 16'h0000);
    random_requests(22);
    drain();

    write_reg(CFG_R_COEFF, 16'd0);
    write_reg(CFG_SRC_EN, 16'd0);
    write_reg(CFG_BG_TEMP, 16'h0000);
    write_reg(CFG_RECT_ROWS, 16'($urandom));
    write_reg(CFG_RECT_COLS, 16'($urandom));
    write_reg(CFG_SRC_TEMP, 16'($urandom));
    in_idle_pct = 16;
    out_stall_pct = 16;
    push_req(MODE_INIT, 0, 0, 16'h0000);
    random_requests(22);
    drain();

    if (errors == 0) begin
      $display("** heat_diffusion_grid_step_core: PASSED **");
    end else begin
      $display("** heat_diffusion_grid_step_core: FAILED **");
    end
    $finish;
  end

endmodule
